@@ hw/rtl/sps_pkg.sv @@
// ---------------------------------------------------------------------------
// sps_pkg
// Shared constants, state codes and the xorshift32 step for the seeded
// permutation shuffle.
// ---------------------------------------------------------------------------
package sps_pkg;

   localparam int MAX_COUNT   = 64;
   localparam int CNT_W       = 7;
   localparam int SEED_W      = 32;
   localparam int VAL_W       = 6;
   localparam int STORE_DEPTH = 64;
   localparam int BIT_CNT_W   = $clog2(SEED_W);
   localparam int REQ_DATA_W  = ((CNT_W + SEED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((VAL_W + 7) / 8) * 8;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE    = 4'd0;
   localparam logic [STATE_W-1:0] S_FILL    = 4'd1;
   localparam logic [STATE_W-1:0] S_STEP    = 4'd2;
   localparam logic [STATE_W-1:0] S_DIV     = 4'd3;
   localparam logic [STATE_W-1:0] S_RDA     = 4'd4;
   localparam logic [STATE_W-1:0] S_RDB     = 4'd5;
   localparam logic [STATE_W-1:0] S_WRA     = 4'd6;
   localparam logic [STATE_W-1:0] S_WRB     = 4'd7;
   localparam logic [STATE_W-1:0] S_EMIT_RD = 4'd8;
   localparam logic [STATE_W-1:0] S_LOAD    = 4'd9;
   localparam logic [STATE_W-1:0] S_WAIT    = 4'd10;

   localparam logic [CNT_W-1:0] CNT_ONE = 7'd1;
   localparam logic [CNT_W-1:0] CNT_TWO = 7'd2;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

   function automatic logic [SEED_W-1:0] xs32(input logic [SEED_W-1:0] x);
      logic [SEED_W-1:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
   endfunction

endpackage

@@ hw/rtl/sps_ram.sv @@
// ---------------------------------------------------------------------------
// sps_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/seeded_permutation_shuffle.sv @@
// ---------------------------------------------------------------------------
// seeded_permutation_shuffle
// Fisher-Yates shuffle of 0..count-1 driven by an xorshift32 generator.
// ---------------------------------------------------------------------------
// Usage: a request transfer on req_ carries a count (saturated to 64) and
// a 32-bit seed. The block writes the identity permutation into its order
// RAM, mixes seed|1 once, then for index = count down to 2 advances the
// generator, forms (state mod index) one bit per cycle with a restoring
// remainder loop, and swaps entries index-1 and that remainder through the
// single RAM read port. It then sends count response transfers on rsp_,
// with rsp_tlast on the final value. A count of zero gives no response.
// Per request the block takes an accept step and a fill step per entry;
// each swap takes a generator step, a remainder step per state bit, RAM
// reads of both entries and writes of both, and each response value goes
// through read, load and wait states, the last held until rsp_tready.
// The remainder loop and the one RAM read port set the total time.
// One request is handled at a time: req_tready is high only while idle.
// A stalled receiver holds the response register; work resumes on its
// transfer. Reset returns the controller to idle and drops rsp_tvalid; the
// RAM contents are not cleared.
// ---------------------------------------------------------------------------
module seeded_permutation_shuffle (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [6:0] count, [38:7] seed, [39] zero
   input  logic [sps_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [5:0] value, [7:6] zero
   output logic [sps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import sps_pkg::*;

   logic [STATE_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [SEED_W-1:0]    rng_ff, rng_in;
   logic [SEED_W-1:0]    shreg_ff, shreg_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [VAL_W-1:0]     ptr_ff, ptr_in;
   logic [VAL_W-1:0]     hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 wr_en;
   logic [VAL_W-1:0]     wr_addr, wr_data, rd_addr, rd_data;

   logic [CNT_W-1:0]     req_count, sat_count, ptr_next;
   logic [SEED_W-1:0]    req_seed;
   logic [VAL_W:0]       trial;
   logic [VAL_W-1:0]     swap_a;

   assign req_count = req_tdata[CNT_W-1:0];
   assign req_seed  = req_tdata[CNT_W+SEED_W-1:CNT_W];
   assign sat_count = (req_count > CNT_MAX) ? CNT_MAX : req_count;
   assign ptr_next  = {1'b0, ptr_ff} + CNT_ONE;
   assign trial     = {rem_ff, shreg_ff[SEED_W-1]};
   assign swap_a    = VAL_W'(idx_ff - CNT_ONE);

   sps_ram #(
      .WIDTH (VAL_W),
      .DEPTH (STORE_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      rng_in       = rng_ff;
      shreg_in     = shreg_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      ptr_in       = ptr_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = ptr_ff;
      rd_addr      = ptr_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               n_in     = sat_count;
               idx_in   = sat_count;
               rng_in   = xs32(req_seed | SEED_W'(1));
               ptr_in   = '0;
               state_in = (sat_count == '0) ? S_IDLE : S_FILL;
            end
         end
         S_FILL: begin
            wr_en  = 1'b1;
            ptr_in = ptr_next[VAL_W-1:0];
            if (ptr_next == n_ff) begin
               ptr_in   = '0;
               state_in = (n_ff > CNT_ONE) ? S_STEP : S_EMIT_RD;
            end
         end
         S_STEP: begin
            rng_in   = xs32(rng_ff);
            shreg_in = xs32(rng_ff);
            rem_in   = '0;
            bit_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring remainder, one state bit per cycle, MSB first
            if (trial >= idx_ff) begin
               rem_in = VAL_W'(trial - idx_ff);
            end else begin
               rem_in = trial[VAL_W-1:0];
            end
            shreg_in = shreg_ff << 1;
            bit_in   = bit_ff + 1'b1;
            if (bit_ff == BIT_CNT_W'(SEED_W - 1)) begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            rd_addr  = swap_a;
            state_in = S_RDB;
         end
         S_RDB: begin
            rd_addr  = rem_ff;
            hold_in  = rd_data;
            state_in = S_WRA;
         end
         S_WRA: begin
            wr_en    = 1'b1;
            wr_addr  = swap_a;
            wr_data  = rd_data;
            state_in = S_WRB;
         end
         S_WRB: begin
            wr_en    = 1'b1;
            wr_addr  = rem_ff;
            wr_data  = hold_ff;
            idx_in   = idx_ff - CNT_ONE;
            state_in = (idx_ff == CNT_TWO) ? S_EMIT_RD : S_STEP;
         end
         S_EMIT_RD: begin
            rd_addr  = ptr_ff;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_last_in  = (ptr_next == n_ff);
            state_in     = S_WAIT;
         end
         S_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               ptr_in       = ptr_next[VAL_W-1:0];
               state_in     = rsp_last_ff ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rng_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rng_ff       <= rng_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      shreg_ff     <= shreg_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      ptr_ff       <= ptr_in;
      hold_ff      <= hold_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_valid_in_wait : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == S_WAIT))
      else $error("response valid outside wait state");

   a_no_accept_while_busy : assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request ready while a response is pending");

   a_rem_below_idx : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ({1'b0, rem_ff} < idx_ff))
      else $error("partial remainder not below divisor");

   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("not idle after final response transfer");

   a_swap_idx_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> ((idx_ff >= CNT_TWO) && (idx_ff <= CNT_MAX)))
      else $error("swap index out of range");
`endif

endmodule
